@@ src/eot_pkg.sv @@
// Shared types, widths and codes for the extent offset translator.
`default_nettype none

package eot_pkg;

	localparam int MAX_EXTENTS_DEF = 8;
	// A load can address only this many table entries.
	localparam int SLOT_COUNT = 8;

	localparam int OP_W    = 2;
	localparam int SLOT_W  = 3;
	localparam int BANK_W  = 8;
	localparam int ADDR_W  = 16;
	localparam int OFF_W   = 24;
	localparam int EXT_W   = 4;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_SEEK = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic KIND_CHUNK = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_EOF = 1'b1;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
	} ext_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic              valid;
		ext_entry_t        entry;
	} tbl_wr_t;

	typedef struct packed {
		logic              kind;
		logic [BANK_W-1:0] bank;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] covered;
		logic              status;
		logic [EXT_W-1:0]  ext;
		logic [ADDR_W-1:0] pos;
		logic [OFF_W-1:0]  off;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

@@ src/eot_table.sv @@
// Extent table: synchronous memory for bank, start and size, with valid flags in flip-flops.
`default_nettype none

module eot_table #(
	parameter int MAX_EXTENTS = eot_pkg::MAX_EXTENTS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  eot_pkg::tbl_wr_t              wr,
	input  wire  [eot_pkg::EXT_W-1:0]     rd_idx,
	output eot_pkg::ext_entry_t           rd_entry,
	input  wire  [eot_pkg::EXT_W-1:0]     chk_idx,
	output logic                          chk_usable
);
	import eot_pkg::*;

	localparam int DEPTH = (MAX_EXTENTS < SLOT_COUNT) ? MAX_EXTENTS : SLOT_COUNT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = 1 << AW;

	ext_entry_t       mem [DEPTH];
	ext_entry_t       rd_q;
	logic [DEPTH-1:0] valid_q;
	logic [VW-1:0]    valid_pad;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.entry;
		end
		rd_q <= mem[rd_idx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr[AW-1:0]] <= wr.valid;
		end
	end

	assign valid_pad  = VW'(valid_q);
	assign chk_usable = (int'(chk_idx) < DEPTH) && valid_pad[chk_idx[AW-1:0]];
	assign rd_entry   = rd_q;

endmodule

`default_nettype wire

@@ src/eot_walker.sv @@
// Operation sequencer: walks the extent table for seeks and reads and produces result items.
`default_nettype none

module eot_walker #(
	parameter int MAX_EXTENTS = eot_pkg::MAX_EXTENTS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [eot_pkg::OP_W-1:0]       operation,
	input  wire  [eot_pkg::SLOT_W-1:0]     extent_slot,
	input  wire                            extent_valid,
	input  wire  [eot_pkg::BANK_W-1:0]     extent_bank,
	input  wire  [eot_pkg::ADDR_W-1:0]     extent_start,
	input  wire  [eot_pkg::ADDR_W-1:0]     extent_end,
	input  wire  [eot_pkg::OFF_W-1:0]      seek_offset,
	input  wire  [eot_pkg::ADDR_W-1:0]     read_count,
	output eot_pkg::tbl_wr_t               tbl_wr,
	output logic [eot_pkg::EXT_W-1:0]      rd_idx,
	input  eot_pkg::ext_entry_t            rd_entry,
	output logic [eot_pkg::EXT_W-1:0]      chk_idx,
	input  wire                            chk_usable,
	input  wire                            res_room,
	output logic                           res_push,
	output eot_pkg::result_t               res
);
	import eot_pkg::*;

	localparam int DEPTH = (MAX_EXTENTS < SLOT_COUNT) ? MAX_EXTENTS : SLOT_COUNT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_EMIT, ST_DONE} state_t;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] len;
	} chunk_t;

	state_t             state_q;
	logic               is_seek_q;
	logic [EXT_W-1:0]   idx_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [OFF_W-1:0]   off_q;
	logic [OFF_W-1:0]   rest_q;
	logic [OFF_W-1:0]   target_q;
	logic [ADDR_W-1:0]  n_q;
	logic [ADDR_W-1:0]  cov_q;
	logic               status_q;
	logic [EXT_W-1:0]   cur_ext_q;
	logic [ADDR_W-1:0]  cur_pos_q;
	logic [OFF_W-1:0]   offset_q;
	logic [CW-1:0]      nchunk_q;
	logic [CW-1:0]      emit_q;
	chunk_t             chunk_buf_q [DEPTH];

	logic               accept;
	logic [ADDR_W-1:0]  left;
	logic [ADDR_W-1:0]  chunk;
	logic [ADDR_W-1:0]  pos_sum;
	logic               past_end;
	logic               seek_hit;
	logic               read_step;
	chunk_t             emit_chunk;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign tbl_wr.en          = accept && (operation == OP_LOAD) && (int'(extent_slot) < DEPTH);
	assign tbl_wr.addr        = extent_slot;
	assign tbl_wr.valid       = extent_valid;
	assign tbl_wr.entry.bank  = extent_bank;
	assign tbl_wr.entry.start = extent_start;
	assign tbl_wr.entry.size  = extent_end - extent_start;

	// The walk only ever moves forward one extent, so the next entry is fetched speculatively.
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_idx = (operation == OP_SEEK) ? '0 : cur_ext_q;
		end else begin
			rd_idx = idx_q + EXT_W'(1);
		end
	end

	assign chk_idx   = idx_q;
	assign left      = rd_entry.size - pos_q;
	assign chunk     = (n_q < left) ? n_q : left;
	assign pos_sum   = pos_q + chunk;
	assign past_end  = (pos_sum >= rd_entry.size);
	assign seek_hit  = (rest_q < OFF_W'(rd_entry.size));
	assign read_step = (state_q == ST_WALK) && !is_seek_q && (n_q != '0) && chk_usable;

	always_ff @(posedge clk) begin
		if (read_step && (chunk != '0)) begin
			chunk_buf_q[nchunk_q[AW-1:0]] <= '{bank: rd_entry.bank,
				addr: rd_entry.start + pos_q, len: chunk};
		end
	end

	assign emit_chunk = chunk_buf_q[emit_q[AW-1:0]];
	assign res_push   = res_room && ((state_q == ST_EMIT) || (state_q == ST_DONE));

	always_comb begin
		res.ext = cur_ext_q;
		res.pos = cur_pos_q;
		res.off = offset_q;
		if (state_q == ST_EMIT) begin
			res.kind    = KIND_CHUNK;
			res.bank    = emit_chunk.bank;
			res.addr    = emit_chunk.addr;
			res.len     = emit_chunk.len;
			res.covered = '0;
			res.status  = STAT_OK;
			res.last    = 1'b0;
		end else begin
			res.kind    = KIND_DONE;
			res.bank    = '0;
			res.addr    = '0;
			res.len     = '0;
			res.covered = cov_q;
			res.status  = status_q;
			res.last    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			is_seek_q <= 1'b0;
			idx_q     <= '0;
			pos_q     <= '0;
			off_q     <= '0;
			rest_q    <= '0;
			target_q  <= '0;
			n_q       <= '0;
			cov_q     <= '0;
			status_q  <= STAT_OK;
			cur_ext_q <= '0;
			cur_pos_q <= '0;
			offset_q  <= '0;
			nchunk_q  <= '0;
			emit_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cov_q    <= '0;
						status_q <= STAT_OK;
						case (operation)
							OP_SEEK: begin
								is_seek_q <= 1'b1;
								idx_q     <= '0;
								rest_q    <= seek_offset;
								target_q  <= seek_offset;
								state_q   <= ST_WALK;
							end
							OP_READ: begin
								is_seek_q <= 1'b0;
								idx_q     <= cur_ext_q;
								pos_q     <= cur_pos_q;
								off_q     <= offset_q;
								n_q       <= read_count;
								nchunk_q  <= '0;
								state_q   <= ST_WALK;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (is_seek_q) begin
						if (!chk_usable) begin
							// Offset lies beyond the last extent: state is left alone.
							status_q <= STAT_EOF;
							state_q  <= ST_DONE;
						end else if (seek_hit) begin
							cur_ext_q <= idx_q;
							cur_pos_q <= rest_q[ADDR_W-1:0];
							offset_q  <= target_q;
							state_q   <= ST_DONE;
						end else begin
							rest_q <= rest_q - OFF_W'(rd_entry.size);
							idx_q  <= idx_q + EXT_W'(1);
						end
					end else if (read_step) begin
						cov_q <= cov_q + chunk;
						n_q   <= n_q - chunk;
						off_q <= off_q + OFF_W'(chunk);
						if (chunk != '0) begin
							nchunk_q <= nchunk_q + CW'(1);
						end
						if (past_end) begin
							idx_q <= idx_q + EXT_W'(1);
							pos_q <= '0;
						end else begin
							pos_q <= pos_sum;
						end
					end else begin
						cur_ext_q <= idx_q;
						cur_pos_q <= pos_q;
						offset_q  <= off_q;
						status_q  <= (n_q != '0) ? STAT_EOF : STAT_OK;
						emit_q    <= '0;
						state_q   <= (nchunk_q != '0) ? ST_EMIT : ST_DONE;
					end
				end
				ST_EMIT: begin
					if (res_room) begin
						if (emit_q == nchunk_q - CW'(1)) begin
							state_q <= ST_DONE;
						end else begin
							emit_q <= emit_q + CW'(1);
						end
					end
				end
				ST_DONE: begin
					if (res_room) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/extent_offset_translator.sv @@
// Top level of the extent offset translator: extent table, sequencer and output register.
`default_nettype none

// Translates linear offsets of one open file into bank/address chunks over a table of up to
// eight extents. Items are taken one at a time. A load, or an unknown operation, goes straight
// to its done transfer. A seek walks the table from the first extent to the one that holds the
// offset and then gives its done transfer; a read walks the extents that it visits, then gives
// one transfer per chunk and then the done transfer, since the current position is reported on
// every result and is known only when the walk ends. The walk steps one extent per cycle, limited
// by the single read port of the extent memory. The output register lets the next item be
// accepted while the last done transfer is still waiting. The table comes out of reset with every
// entry invalid; no clearing pass is needed.
module extent_offset_translator #(
	parameter int MAX_EXTENTS = eot_pkg::MAX_EXTENTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [eot_pkg::OP_W-1:0]     operation,
	input  wire  [eot_pkg::SLOT_W-1:0]   extent_slot,
	input  wire                          extent_valid,
	input  wire  [eot_pkg::BANK_W-1:0]   extent_bank,
	input  wire  [eot_pkg::ADDR_W-1:0]   extent_start,
	input  wire  [eot_pkg::ADDR_W-1:0]   extent_end,
	input  wire  [eot_pkg::OFF_W-1:0]    seek_offset,
	input  wire  [eot_pkg::ADDR_W-1:0]   read_count,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         result_kind,
	output logic [eot_pkg::BANK_W-1:0]   chunk_bank,
	output logic [eot_pkg::ADDR_W-1:0]   chunk_address,
	output logic [eot_pkg::ADDR_W-1:0]   chunk_length,
	output logic [eot_pkg::ADDR_W-1:0]   bytes_covered,
	output logic                         status,
	output logic [eot_pkg::EXT_W-1:0]    extent_now,
	output logic [eot_pkg::ADDR_W-1:0]   position_now,
	output logic [eot_pkg::OFF_W-1:0]    offset_now,
	output logic                         last
);
	import eot_pkg::*;

	tbl_wr_t          tbl_wr;
	logic [EXT_W-1:0] rd_idx;
	ext_entry_t       rd_entry;
	logic [EXT_W-1:0] chk_idx;
	logic             chk_usable;
	logic             res_room;
	logic             res_push;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	eot_table #(
		.MAX_EXTENTS (MAX_EXTENTS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (tbl_wr),
		.rd_idx     (rd_idx),
		.rd_entry   (rd_entry),
		.chk_idx    (chk_idx),
		.chk_usable (chk_usable)
	);

	eot_walker #(
		.MAX_EXTENTS (MAX_EXTENTS)
	) u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.extent_slot  (extent_slot),
		.extent_valid (extent_valid),
		.extent_bank  (extent_bank),
		.extent_start (extent_start),
		.extent_end   (extent_end),
		.seek_offset  (seek_offset),
		.read_count   (read_count),
		.tbl_wr       (tbl_wr),
		.rd_idx       (rd_idx),
		.rd_entry     (rd_entry),
		.chk_idx      (chk_idx),
		.chk_usable   (chk_usable),
		.res_room     (res_room),
		.res_push     (res_push),
		.res          (res)
	);

	// The register may be refilled in the same cycle as its transfer completes.
	assign res_room = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = out_q.kind;
	assign chunk_bank    = out_q.bank;
	assign chunk_address = out_q.addr;
	assign chunk_length  = out_q.len;
	assign bytes_covered = out_q.covered;
	assign status        = out_q.status;
	assign extent_now    = out_q.ext;
	assign position_now  = out_q.pos;
	assign offset_now    = out_q.off;
	assign last          = out_q.last;

endmodule

`default_nettype wire

@@ src/eot_checker.sv @@
// Port-level checks for the extent offset translator, bound to its top level.
`default_nettype none

module eot_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire  [eot_pkg::OP_W-1:0]     operation,
	input wire  [eot_pkg::SLOT_W-1:0]   extent_slot,
	input wire                          extent_valid,
	input wire  [eot_pkg::BANK_W-1:0]   extent_bank,
	input wire  [eot_pkg::ADDR_W-1:0]   extent_start,
	input wire  [eot_pkg::ADDR_W-1:0]   extent_end,
	input wire  [eot_pkg::OFF_W-1:0]    seek_offset,
	input wire  [eot_pkg::ADDR_W-1:0]   read_count,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire                          result_kind,
	input wire  [eot_pkg::BANK_W-1:0]   chunk_bank,
	input wire  [eot_pkg::ADDR_W-1:0]   chunk_address,
	input wire  [eot_pkg::ADDR_W-1:0]   chunk_length,
	input wire  [eot_pkg::ADDR_W-1:0]   bytes_covered,
	input wire                          status,
	input wire  [eot_pkg::EXT_W-1:0]    extent_now,
	input wire  [eot_pkg::ADDR_W-1:0]   position_now,
	input wire  [eot_pkg::OFF_W-1:0]    offset_now,
	input wire                          last
);
	import eot_pkg::*;

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(chunk_length)
			&& $stable(chunk_address) && $stable(offset_now) && $stable(last))
		else $error("stalled result changed");

	// A chunk transfer is never the last one, never empty and never flags end of file.
	a_chunk_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_CHUNK) |->
			!last && (chunk_length != '0) && (status == STAT_OK) && (bytes_covered == '0))
		else $error("malformed chunk transfer");

	// The done transfer closes every item and carries no chunk.
	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_DONE) |->
			last && (chunk_length == '0) && (chunk_bank == '0) && (chunk_address == '0))
		else $error("malformed done transfer");

	// Items are handled one at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

endmodule

bind extent_offset_translator eot_checker u_eot_checker (.*);

`default_nettype wire
